### rtl/core/thick_line_to_quad_expander_macros.svh
// assertion macros used by the checker file of the quad expander
// each macro expects signals named clk and rst in the enclosing scope
`ifndef THICK_LINE_TO_QUAD_EXPANDER_MACROS_SVH
`define THICK_LINE_TO_QUAD_EXPANDER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define TLQE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after its trigger
`define TLQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tlqe_pkg.sv
// types, widths and constants of the thick line to quad expander
// used by every module of the block; depends on nothing
package tlqe_pkg;

  localparam int COORD_W  = 32;
  localparam int WIDTH_W  = 31;
  localparam int COLOR_W  = 32;
  localparam int LAYER_W  = 16;
  localparam int MINLEN_W = 16;
  localparam int CORNER_W = 3;
  localparam int NCORNERS = 6;

  // internal datapath widths
  localparam int DIFF_W = COORD_W + 1;      // end minus start
  localparam int AXIS_W = 31;               // scaled |dx|, |dz|
  localparam int SQ_W   = 2 * AXIS_W;       // one square
  localparam int RAD_W  = 2 * (AXIS_W + 1); // sum of squares, padded to even
  localparam int ROOT_W = AXIS_W + 1;       // horizontal length
  localparam int NUM_W  = SQ_W + 1;         // |d| * w + len
  localparam int DEN_W  = ROOT_W + 1;       // 2 * len
  localparam int QUOT_W = 31;               // offset magnitude
  localparam int SUM_W  = COORD_W + 2;      // vertex before saturation

  localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 16'd66;
  localparam logic [CORNER_W-1:0] FIRST_CORNER     = 3'd0;
  localparam logic [CORNER_W-1:0] LAST_CORNER      = 3'd5;

  // per corner: built on the end point, offset added
  localparam logic [NCORNERS-1:0] END_CORNERS  = 6'b110100;
  localparam logic [NCORNERS-1:0] PLUS_CORNERS = 6'b010110;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [WIDTH_W-1:0]        line_width;
    logic [COLOR_W-1:0]        vertex_color;
    logic [LAYER_W-1:0]        layer_tag;
  } tlqe_seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [COLOR_W-1:0]        out_color;
    logic [LAYER_W-1:0]        out_layer;
    logic [CORNER_W-1:0]       corner_index;
    logic                      last_vertex;
  } tlqe_vtx_t;

  // what travels alongside the length and division pipelines
  typedef struct packed {
    tlqe_seg_t          seg;
    logic               dx_neg;
    logic               dz_pos;
    logic               huge;
    logic [AXIS_W-1:0]  ax;
    logic [AXIS_W-1:0]  az;
  } tlqe_side_t;

  typedef struct packed {
    tlqe_side_t side;
    logic       degen;
  } tlqe_dside_t;

  // one finished segment, ready to be sent as six vertices
  typedef struct packed {
    tlqe_seg_t                 seg;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] pz;
  } tlqe_quad_t;

endpackage

### rtl/core/tlqe_isqrt.sv
// pipelined integer square root, one result bit per register stage
// depends on tlqe_pkg
module tlqe_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tlqe_pkg::RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [tlqe_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]          out_side
);
  import tlqe_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [STEPS-1:0] vld;
  logic [RAD_W-1:0]  rad_q  [STEPS];
  logic [REM_W-1:0]  rem_q  [STEPS];
  logic [ROOT_W-1:0] root_q [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic              v_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld[g-1];
      assign rad_i  = rad_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign root_i = root_q[g-1];
      assign side_i = side_q[g-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial  = {1'b0, root_i, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_q[g]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[g] <= {root_i[ROOT_W-2:0], ge};
        side_q[g] <= side_i;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = root_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule

### rtl/core/tlqe_div.sv
// pipelined restoring divider, two numerators over one shared divisor
// one quotient bit per register stage; depends on tlqe_pkg
module tlqe_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tlqe_pkg::NUM_W-1:0]  num_a,
  input  logic [tlqe_pkg::NUM_W-1:0]  num_b,
  input  logic [tlqe_pkg::DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [tlqe_pkg::QUOT_W-1:0] quot_a,
  output logic [tlqe_pkg::QUOT_W-1:0] quot_b,
  output logic [SIDE_W-1:0]          out_side
);
  import tlqe_pkg::*;

  localparam int STEPS = QUOT_W;
  localparam int REM_W = DEN_W + 1;
  localparam int HEAD_W = NUM_W - QUOT_W;

  logic [STEPS-1:0] vld;
  logic [REM_W-1:0]  rem_a_q [STEPS];
  logic [REM_W-1:0]  rem_b_q [STEPS];
  logic [QUOT_W-1:0] low_a_q [STEPS];
  logic [QUOT_W-1:0] low_b_q [STEPS];
  logic [QUOT_W-1:0] q_a_q   [STEPS];
  logic [QUOT_W-1:0] q_b_q   [STEPS];
  logic [DEN_W-1:0]  den_q   [STEPS];
  logic [SIDE_W-1:0] side_q  [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic              v_i;
    logic [REM_W-1:0]  rem_a_i, rem_b_i, sh_a, sh_b, den_x;
    logic [QUOT_W-1:0] low_a_i, low_b_i, q_a_i, q_b_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic              ge_a, ge_b;

    if (g == 0) begin : g_first
      assign v_i     = in_valid;
      assign rem_a_i = {{(REM_W-HEAD_W){1'b0}}, num_a[NUM_W-1:QUOT_W]};
      assign rem_b_i = {{(REM_W-HEAD_W){1'b0}}, num_b[NUM_W-1:QUOT_W]};
      assign low_a_i = num_a[QUOT_W-1:0];
      assign low_b_i = num_b[QUOT_W-1:0];
      assign q_a_i   = '0;
      assign q_b_i   = '0;
      assign den_i   = den;
      assign side_i  = in_side;
    end else begin : g_next
      assign v_i     = vld[g-1];
      assign rem_a_i = rem_a_q[g-1];
      assign rem_b_i = rem_b_q[g-1];
      assign low_a_i = low_a_q[g-1];
      assign low_b_i = low_b_q[g-1];
      assign q_a_i   = q_a_q[g-1];
      assign q_b_i   = q_b_q[g-1];
      assign den_i   = den_q[g-1];
      assign side_i  = side_q[g-1];
    end

    // shift in the next numerator bit and subtract where it fits
    always_comb begin
      den_x = {1'b0, den_i};
      sh_a  = {rem_a_i[REM_W-2:0], low_a_i[QUOT_W-1]};
      sh_b  = {rem_b_i[REM_W-2:0], low_b_i[QUOT_W-1]};
      ge_a  = (sh_a >= den_x);
      ge_b  = (sh_b >= den_x);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a_q[g] <= ge_a ? (sh_a - den_x) : sh_a;
        rem_b_q[g] <= ge_b ? (sh_b - den_x) : sh_b;
        low_a_q[g] <= {low_a_i[QUOT_W-2:0], 1'b0};
        low_b_q[g] <= {low_b_i[QUOT_W-2:0], 1'b0};
        q_a_q[g]   <= {q_a_i[QUOT_W-2:0], ge_a};
        q_b_q[g]   <= {q_b_i[QUOT_W-2:0], ge_b};
        den_q[g]   <= den_i;
        side_q[g]  <= side_i;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign quot_a    = q_a_q[STEPS-1];
  assign quot_b    = q_b_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule

### rtl/core/tlqe_serializer.sv
// holds one finished quad and sends its six corners, one beat each
// depends on tlqe_pkg
module tlqe_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tlqe_pkg::tlqe_quad_t in_quad,
  output logic                 take,
  output logic                 vtx_valid,
  input  logic                 vtx_stall,
  output tlqe_pkg::tlqe_vtx_t  vtx_data
);
  import tlqe_pkg::*;

  logic                 busy;
  logic [CORNER_W-1:0]  cnt;
  tlqe_quad_t           quad;

  logic                       at_end, plus;
  logic signed [COORD_W-1:0]  bx, bz;
  logic signed [SUM_W-1:0]    sum_x, sum_z;

  // room for a new quad when empty or when the last corner leaves now
  assign take = !busy || (cnt == LAST_CORNER && !vtx_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= FIRST_CORNER;
    end else if (take && in_valid) begin
      busy <= 1'b1;
      cnt  <= FIRST_CORNER;
    end else if (take) begin
      busy <= 1'b0;
    end else if (!vtx_stall) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      quad <= in_quad;
    end
  end

  // corner position: base point plus or minus the offset, saturated
  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [2:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[COORD_W-1:0];
    end
    return v[SUM_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  always_comb begin
    at_end = END_CORNERS[cnt];
    plus   = PLUS_CORNERS[cnt];
    bx     = at_end ? quad.seg.end_x : quad.seg.start_x;
    bz     = at_end ? quad.seg.end_z : quad.seg.start_z;
    if (plus) begin
      sum_x = SUM_W'(bx) + SUM_W'(quad.px);
      sum_z = SUM_W'(bz) + SUM_W'(quad.pz);
    end else begin
      sum_x = SUM_W'(bx) - SUM_W'(quad.px);
      sum_z = SUM_W'(bz) - SUM_W'(quad.pz);
    end
    vtx_data.out_x        = sat(sum_x);
    vtx_data.out_y        = at_end ? quad.seg.end_y : quad.seg.start_y;
    vtx_data.out_z        = sat(sum_z);
    vtx_data.out_color    = quad.seg.vertex_color;
    vtx_data.out_layer    = quad.seg.layer_tag;
    vtx_data.corner_index = cnt;
    vtx_data.last_vertex  = (cnt == LAST_CORNER);
  end

  assign vtx_valid = busy;

endmodule

### rtl/core/thick_line_to_quad_expander.sv
// Thick line to quad expander. Takes one segment beat (two end points, a
// full width, a color and a layer) and sends six vertex beats forming two
// triangles: s-p, s+p, e+p, s-p, e+p, e-p, the last one flagged. The offset
// p is perpendicular in the x-z plane with length width/2; segments whose
// horizontal length is at or below min_length get p = (width/2, 0). A new
// segment can enter every cycle while the pipeline has room; the sustained
// rate is one segment per six vertices, set by the output stage sending one
// vertex per beat. From segment accept to the first vertex a segment passes
// through four setup stages, 32 square root stages, two multiply/add stages,
// 31 divider stages and the output register. While a finished quad waits for
// the output stage the whole pipeline holds, so vertex-side stalls back up to
// the segment side. min_length resets to 66; the user must write it only
// while the block is idle, which the block itself does not enforce.
// depends on tlqe_pkg, tlqe_isqrt, tlqe_div and tlqe_serializer
module thick_line_to_quad_expander (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tlqe_pkg::MINLEN_W-1:0]       cfg_wdata,
  input  logic                                seg_valid,
  output logic                                seg_stall,
  input  tlqe_pkg::tlqe_seg_t                 seg_data,
  output logic                                vtx_valid,
  input  logic                                vtx_stall,
  output tlqe_pkg::tlqe_vtx_t                 vtx_data
);
  import tlqe_pkg::*;

  logic en, take;
  logic [MINLEN_W-1:0] min_length;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_length <= cfg_wdata;
    end
  end

  // stage 1: differences
  logic                v1;
  tlqe_seg_t           seg1;
  logic [DIFF_W-1:0]   dx1, dz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg1 <= seg_data;
      dx1  <= {seg_data.end_x[COORD_W-1], seg_data.end_x}
            - {seg_data.start_x[COORD_W-1], seg_data.start_x};
      dz1  <= {seg_data.end_z[COORD_W-1], seg_data.end_z}
            - {seg_data.start_z[COORD_W-1], seg_data.start_z};
    end
  end

  // stage 2: magnitudes, scaled down so the larger fits the multipliers
  logic              v2;
  tlqe_side_t        side2;
  logic [DIFF_W-1:0] ax_f, az_f, m_f;
  logic [1:0]        shamt;
  logic [DIFF_W-1:0] ax_s, az_s;

  always_comb begin
    ax_f = dx1[DIFF_W-1] ? (~dx1 + 1'b1) : dx1;
    az_f = dz1[DIFF_W-1] ? (~dz1 + 1'b1) : dz1;
    m_f  = (ax_f > az_f) ? ax_f : az_f;
    if (m_f[DIFF_W-1]) begin
      shamt = 2'd2;
    end else if (m_f[DIFF_W-2]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
    ax_s = ax_f >> shamt;
    az_s = az_f >> shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2.seg    <= seg1;
      side2.dx_neg <= dx1[DIFF_W-1];
      side2.dz_pos <= !dz1[DIFF_W-1] && (dz1 != '0);
      side2.huge   <= (shamt != 2'd0);
      side2.ax     <= ax_s[AXIS_W-1:0];
      side2.az     <= az_s[AXIS_W-1:0];
    end
  end

  // stage 3: squares
  logic            v3;
  tlqe_side_t      side3;
  logic [SQ_W-1:0] sqx3, sqz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      sqx3  <= side2.ax * side2.ax;
      sqz3  <= side2.az * side2.az;
    end
  end

  // stage 4: sum of squares
  logic             v4;
  tlqe_side_t       side4;
  logic [RAD_W-1:0] rad4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      rad4  <= RAD_W'(sqx3) + RAD_W'(sqz3);
    end
  end

  // horizontal length
  logic              v5;
  logic [ROOT_W-1:0] len5;
  tlqe_side_t        side5;

  tlqe_isqrt #(
    .SIDE_W ($bits(tlqe_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .rad       (rad4),
    .in_side   (side4),
    .out_valid (v5),
    .root      (len5),
    .out_side  (side5)
  );

  // stage 6: products and degenerate test
  logic              v6;
  tlqe_side_t        side6;
  logic [ROOT_W-1:0] len6;
  logic [SQ_W-1:0]   prx6, prz6;
  logic              degen6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6  <= side5;
      len6   <= len5;
      prx6   <= side5.az * side5.seg.line_width;
      prz6   <= side5.ax * side5.seg.line_width;
      degen6 <= !side5.huge && (len5 <= ROOT_W'(min_length));
    end
  end

  // stage 7: rounding term and divisor
  logic             v7;
  tlqe_dside_t      dside7;
  logic [NUM_W-1:0] numx7, numz7;
  logic [DEN_W-1:0] den7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside7.side  <= side6;
      dside7.degen <= degen6;
      numx7        <= NUM_W'(prx6) + NUM_W'(len6);
      numz7        <= NUM_W'(prz6) + NUM_W'(len6);
      den7         <= {len6, 1'b0};
    end
  end

  // offset magnitudes
  logic              v8;
  logic [QUOT_W-1:0] mx8, mz8;
  tlqe_dside_t       dside8;

  tlqe_div #(
    .SIDE_W ($bits(tlqe_dside_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .num_a     (numx7),
    .num_b     (numz7),
    .den       (den7),
    .in_side   (dside7),
    .out_valid (v8),
    .quot_a    (mx8),
    .quot_b    (mz8),
    .out_side  (dside8)
  );

  // signed offsets for the output stage
  tlqe_quad_t                quad8;
  logic signed [COORD_W-1:0] mxs, mzs;
  logic [WIDTH_W:0]          half_w;

  always_comb begin
    mxs          = COORD_W'(mx8);
    mzs          = COORD_W'(mz8);
    half_w       = ({1'b0, dside8.side.seg.line_width} + 1'b1) >> 1;
    quad8.seg    = dside8.side.seg;
    if (dside8.degen) begin
      quad8.px = COORD_W'(half_w);
      quad8.pz = '0;
    end else begin
      quad8.px = dside8.side.dz_pos ? -mxs : mxs;
      quad8.pz = dside8.side.dx_neg ? -mzs : mzs;
    end
  end

  // whole pipeline moves unless a finished quad is waiting for the output
  assign en        = !v8 || take;
  assign seg_stall = !en;

  tlqe_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .in_quad   (quad8),
    .take      (take),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx_data  (vtx_data)
  );

endmodule

### rtl/core/tlqe_checker.sv
// port level checks of the quad expander output, bound to the top level
// depends on tlqe_pkg and the assertion macro header
`include "thick_line_to_quad_expander_macros.svh"

module tlqe_checker (
  input logic                clk,
  input logic                rst,
  input logic                vtx_valid,
  input logic                vtx_stall,
  input tlqe_pkg::tlqe_vtx_t vtx_data
);
  import tlqe_pkg::*;

  logic mid_beat;

  // a corner that is not the last one leaves the output
  assign mid_beat = vtx_valid && !vtx_stall && (vtx_data.corner_index != LAST_CORNER);

  `TLQE_ASSERT_NEXT(a_stall_hold, vtx_valid && vtx_stall, vtx_valid && $stable(vtx_data), "vertex beat changed under stall")
  `TLQE_ASSERT_NEXT(a_corner_seq, mid_beat, vtx_valid && (vtx_data.corner_index == $past(vtx_data.corner_index) + 3'd1), "quad corners not sent back to back in order")
  `TLQE_ASSERT_NEXT(a_quad_color, mid_beat, vtx_data.out_color == $past(vtx_data.out_color), "color changed inside a quad")
  `TLQE_ASSERT_NOW(a_last_flag, vtx_valid, vtx_data.last_vertex == (vtx_data.corner_index == LAST_CORNER), "last flag off the sixth corner")

endmodule

bind thick_line_to_quad_expander tlqe_checker u_tlqe_checker (
  .clk       (clk),
  .rst       (rst),
  .vtx_valid (vtx_valid),
  .vtx_stall (vtx_stall),
  .vtx_data  (vtx_data)
);
